// ===== rtl/cdr_pkg.sv =====
package cdr_pkg;

    // Field widths of the transaction payloads
    localparam int MODE_W  = 1;
    localparam int VAL_W   = 7;
    localparam int LEN_W   = 7;
    localparam int ROT_W   = 6;
    localparam int TOT_W   = 16;
    localparam int REM_W   = 7;

    // Saturation limits and reset value of the length register
    localparam int               ROT_MAX    = 63;
    localparam logic [TOT_W-1:0] TOT_MAX    = 16'hFFFF;
    localparam logic [LEN_W-1:0] LEN_RESET  = 7'd64;

    // Mode codes of an input transaction
    localparam logic [MODE_W-1:0] MODE_RESTART = 1'b0;
    localparam logic [MODE_W-1:0] MODE_DRAW    = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [VAL_W-1:0]  draw_value;
    } in_item_t;

    typedef struct packed {
        logic [ROT_W-1:0] rotations;
        logic             went_right;
        logic             not_found;
        logic [TOT_W-1:0] total_operations;
        logic [REM_W-1:0] remaining;
    } out_item_t;

endpackage

// ===== rtl/cdr_ring.sv =====
module cdr_ring #(
    parameter int DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [$clog2(DEPTH)-1:0]            wr_addr,
    input  logic [cdr_pkg::VAL_W-1:0]           wr_data,
    input  logic                                rd_en,
    input  logic [$clog2(DEPTH)-1:0]            rd_addr,
    output logic [cdr_pkg::VAL_W-1:0]           rd_data
);
    import cdr_pkg::*;

    logic [VAL_W-1:0] mem_reg [DEPTH];
    logic [VAL_W-1:0] rd_data_reg;

    // Write one slot per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/cdr_modadd.sv =====
module cdr_modadd #(
    parameter int DEPTH = 64
) (
    input  logic [$clog2(DEPTH)-1:0] base,
    input  logic [$clog2(DEPTH)-1:0] offset,
    output logic [$clog2(DEPTH)-1:0] sum
);
    import cdr_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    logic [IDX_W:0] raw;

    // Add, then fold back once into the ring
    always_comb begin
        raw = {1'b0, base} + {1'b0, offset};
        if (raw >= (IDX_W+1)'(DEPTH)) begin
            sum = IDX_W'(raw - (IDX_W+1)'(DEPTH));
        end else begin
            sum = IDX_W'(raw);
        end
    end

endmodule

// ===== rtl/circular_deque_rotate_draw_unit.sv =====
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_data  (mode, draw_value)
// m_        out        m_valid / m_ready      m_data  (rotations, went_right, not_found,
//                                                      total_operations, remaining)
// cfg_      in         cfg_valid / cfg_ready  cfg_data (queue_length)
//
// Restart: one ring write per loaded value, then the result is presented.
// Draw: a pipelined scan for the value (on a miss the result is presented with no rotation),
// then the direction is decided, then a read and a write per rotation step on the single
// ring port pair, then commit and present; at most DEPTH/2 steps (a left turn). The unit
// then returns to idle to accept the next transaction. The shared modular adder forms every
// ring read address and the rotation write addresses; the fill writes its slots directly.
// Reset (aresetn low, synchronous) empties the deque, zeroes the total, loads length 64.
// s_ready is high only while idle; a result waiting on m_ready holds the next result back.
module circular_deque_rotate_draw_unit #(
    parameter int DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  cdr_pkg::in_item_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output cdr_pkg::out_item_t           m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [cdr_pkg::LEN_W-1:0]    cfg_data
);
    import cdr_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = TOT_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_SCAN,
        S_DECIDE,
        S_READ,
        S_WRITE,
        S_FINISH,
        S_PUSH
    } state_t;

    state_t            state_reg;
    logic [LEN_W-1:0]  cfg_len_reg;
    logic [IDX_W-1:0]  front_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [TOT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [VAL_W-1:0]  want_reg;
    logic [CNT_W-1:0]  issue_off_reg;
    logic [CNT_W-1:0]  chk_off_reg;
    logic              chk_vld_reg;
    logic [CNT_W-1:0]  d_reg;
    logic [CNT_W-1:0]  rot_reg;
    logic              right_reg;
    logic              miss_reg;
    logic [IDX_W-1:0]  src_off_reg;
    logic [IDX_W-1:0]  dst_off_reg;
    logic [IDX_W-1:0]  adv_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic [IDX_W-1:0]  add_b;
    logic [IDX_W-1:0]  add_sum;
    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic [VAL_W-1:0]  rd_data;
    logic              hit;
    logic [CNT_W-1:0]  fill_len;
    logic              go_right;
    logic [CNT_W-1:0]  rot_calc;
    logic [CNT_W-1:0]  adv_raw;
    logic [SUM_W-1:0]  tot_sum;
    out_item_t         result;

    function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] x);
        return (x == IDX_W'(DEPTH - 1)) ? '0 : x + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] dec_wrap(input logic [IDX_W-1:0] x);
        return (x == '0) ? IDX_W'(DEPTH - 1) : x - IDX_W'(1);
    endfunction

    cdr_ring #(.DEPTH(DEPTH)) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (add_sum),
        .rd_data (rd_data)
    );

    cdr_modadd #(.DEPTH(DEPTH)) u_addr (
        .base   (front_reg),
        .offset (add_b),
        .sum    (add_sum)
    );

    assign s_ready   = aresetn && (state_reg == S_IDLE);
    assign cfg_ready = aresetn;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Clamp the loaded length to the ring size
    assign fill_len = (32'(cfg_len_reg) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(cfg_len_reg);

    assign hit = chk_vld_reg && (rd_data == want_reg);

    // Pick the shorter direction and the front advance it leaves behind
    always_comb begin
        go_right = d_reg > (count_reg >> 1);
        rot_calc = go_right ? (count_reg - d_reg) : d_reg;
        if (go_right) begin
            adv_raw = CNT_W'(DEPTH) - rot_calc + CNT_W'(1);
        end else begin
            adv_raw = d_reg + CNT_W'(1);
        end
    end

    assign tot_sum = {1'b0, total_reg} + SUM_W'(rot_reg);

    // Assemble the result from committed state
    always_comb begin
        result.rotations        = (32'(rot_reg) > ROT_MAX) ? ROT_W'(ROT_MAX) : ROT_W'(rot_reg);
        result.went_right       = right_reg;
        result.not_found        = miss_reg;
        result.total_operations = total_reg;
        result.remaining        = REM_W'(count_reg);
    end

    // Steer the shared adder and the ring ports
    always_comb begin
        add_b   = '0;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        case (state_reg)
            S_FILL: begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(k_reg);
                wr_data = VAL_W'(CNT_W'(k_reg + CNT_W'(1)));
            end
            S_SCAN: begin
                add_b = IDX_W'(issue_off_reg);
                rd_en = !hit && (issue_off_reg != count_reg);
            end
            S_READ: begin
                add_b = src_off_reg;
                rd_en = 1'b1;
            end
            S_WRITE: begin
                add_b   = dst_off_reg;
                wr_en   = 1'b1;
                wr_addr = add_sum;
                wr_data = rd_data;
            end
            S_FINISH: begin
                add_b = adv_reg;
            end
            default: begin
                add_b = '0;
            end
        endcase
    end

    // Sequencer, deque state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cfg_len_reg <= LEN_RESET;
            front_reg   <= '0;
            count_reg   <= '0;
            total_reg   <= '0;
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cfg_len_reg <= cfg_data;
            end

            // Drop the result once taken, unless a new one is pushed in the same cycle
            if (m_valid_reg && m_ready && (state_reg != S_PUSH)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        want_reg      <= s_data.draw_value;
                        k_reg         <= '0;
                        issue_off_reg <= '0;
                        chk_vld_reg   <= 1'b0;
                        rot_reg       <= '0;
                        right_reg     <= 1'b0;
                        miss_reg      <= 1'b0;
                        len_reg       <= fill_len;
                        if (s_data.mode == MODE_DRAW) begin
                            state_reg <= S_SCAN;
                        end else if (fill_len == '0) begin
                            front_reg <= '0;
                            count_reg <= '0;
                            total_reg <= '0;
                            state_reg <= S_PUSH;
                        end else begin
                            state_reg <= S_FILL;
                        end
                    end
                end
                S_FILL: begin
                    if (k_reg + CNT_W'(1) == len_reg) begin
                        front_reg <= '0;
                        count_reg <= len_reg;
                        total_reg <= '0;
                        state_reg <= S_PUSH;
                    end else begin
                        k_reg <= k_reg + CNT_W'(1);
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        d_reg       <= chk_off_reg;
                        chk_vld_reg <= 1'b0;
                        state_reg   <= S_DECIDE;
                    end else if (issue_off_reg == count_reg) begin
                        miss_reg    <= 1'b1;
                        chk_vld_reg <= 1'b0;
                        state_reg   <= S_PUSH;
                    end else begin
                        chk_vld_reg   <= 1'b1;
                        chk_off_reg   <= issue_off_reg;
                        issue_off_reg <= issue_off_reg + CNT_W'(1);
                    end
                end
                S_DECIDE: begin
                    rot_reg   <= rot_calc;
                    right_reg <= go_right;
                    k_reg     <= '0;
                    adv_reg   <= (adv_raw == CNT_W'(DEPTH)) ? '0 : IDX_W'(adv_raw);
                    if (go_right) begin
                        src_off_reg <= IDX_W'(count_reg - CNT_W'(1));
                        dst_off_reg <= IDX_W'(DEPTH - 1);
                    end else begin
                        src_off_reg <= '0;
                        dst_off_reg <= (count_reg == CNT_W'(DEPTH)) ? '0 : IDX_W'(count_reg);
                    end
                    state_reg <= (rot_calc == '0) ? S_FINISH : S_READ;
                end
                S_READ: begin
                    state_reg <= S_WRITE;
                end
                S_WRITE: begin
                    if (right_reg) begin
                        src_off_reg <= dec_wrap(src_off_reg);
                        dst_off_reg <= dec_wrap(dst_off_reg);
                    end else begin
                        src_off_reg <= inc_wrap(src_off_reg);
                        dst_off_reg <= inc_wrap(dst_off_reg);
                    end
                    if (k_reg + CNT_W'(1) == rot_reg) begin
                        state_reg <= S_FINISH;
                    end else begin
                        k_reg     <= k_reg + CNT_W'(1);
                        state_reg <= S_READ;
                    end
                end
                S_FINISH: begin
                    // Commit: new front, one fewer entry, saturating total
                    front_reg <= add_sum;
                    count_reg <= count_reg - CNT_W'(1);
                    total_reg <= tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
                    state_reg <= S_PUSH;
                end
                S_PUSH: begin
                    // Hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= result;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
